@@ sv/clock_time_set_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Clock time-set controller assertion macros
// Shared property wrappers for the clock time-set controller RTL.
// ----------------------------------------------------------------------------
`ifndef CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH
`define CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock time-set controller package
// Beat types, key and field codes, and the BCD conversion helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cts_pkg;

  // Key codes
  localparam logic [1:0] KeyReleased = 2'd0;
  localparam logic [1:0] KeyInc      = 2'd1;
  localparam logic [1:0] KeyNext     = 2'd2;

  // Field select codes
  localparam logic [1:0] FieldHours   = 2'd0;
  localparam logic [1:0] FieldMinutes = 2'd1;
  localparam logic [1:0] FieldSeconds = 2'd2;
  localparam logic [1:0] FieldInvalid = 2'd3;

  // Blink phase codes
  localparam logic [1:0] PhaseShow  = 2'd0;
  localparam logic [1:0] PhaseBlank = 2'd1;
  localparam logic [1:0] PhaseIdle  = 2'd2;
  localparam logic [1:0] PhaseBad   = 2'd3;

  // Blink counter limits: show while count <= 5, blank while <= 9
  localparam logic [3:0] BlinkShowLast  = 4'd5;
  localparam logic [3:0] BlinkBlankLast = 4'd9;

  localparam logic [6:0] PressMax      = 7'd127;
  localparam logic [6:0] LongPressRst  = 7'd11;
  localparam logic [5:0] HoursWrap     = 6'd24;
  localparam logic [6:0] MinSecWrap    = 7'd60;

  typedef struct packed {
    logic       action;
    logic [1:0] key;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] selected_field;
    logic [1:0] blink_phase;
    logic       commit;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
  } out_item_t;

  // Input stage status toward the core
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } stage_t;

  // Packed BCD of a 6-bit value: tens = (v * 13) >> 7 is exact for v < 64.
  function automatic logic [6:0] to_bcd(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] units;
    prod  = {4'b0, v} * 10'd13;
    tens  = prod[9:7];
    units = v - ({3'b0, tens} * 6'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

@@ sv/clock_time_set_controller.sv @@
// A key poll beat is held in the input register; its result is registered for out_valid_o.
// Throughput: one beat per cycle unless the result stalls; the edit state updates in one
//   pass between input and result registers, so back-to-back ticks see each other's state.
// Reset (rst_ni low, async): edit time, field, press and blink counters clear,
//   long-press threshold returns to 11, both pipeline valids drop.
// ----------------------------------------------------------------------------
// Clock time-set controller
// Key-driven time editor with blink sequencing, short/long press handling and
// BCD commit of the edited time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "clock_time_set_controller_defines.svh"

module clock_time_set_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Key poll input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cts_pkg::in_item_t   in_data_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cts_pkg::out_item_t  out_data_o,
  // Long-press threshold write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i
);

  cts_pkg::stage_t    stage;
  cts_pkg::out_item_t result;
  logic               adv;
  logic [6:0]         long_press_q;
  logic               out_vld_q;
  cts_pkg::out_item_t out_data_q;

  // The threshold register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= cts_pkg::LongPressRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      long_press_q <= cfg_data_i;
    end
  end

  // Advance the held beat whenever the result register is empty or draining
  assign adv = stage.vld & (~out_vld_q | ~out_stall_i);

  cts_input_stage u_input_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (adv),
    .stage_o    (stage)
  );

  cts_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (stage.item),
    .long_press_i (long_press_q),
    .result_o     (result)
  );

  // Result register: load on advance, hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  `CTS_ASSERT(a_stall_only_when_blocked,
              in_stall_o |-> (out_vld_q && out_stall_i && stage.vld),
              "input stalled without a blocked result")
  `CTS_ASSERT(a_field_code,
              out_vld_q |-> (out_data_q.selected_field != cts_pkg::FieldInvalid),
              "selected field out of range")
  `CTS_ASSERT(a_phase_code,
              out_vld_q |-> (out_data_q.blink_phase != cts_pkg::PhaseBad),
              "blink phase out of range")
  `CTS_ASSERT(a_bcd_zero,
              (out_vld_q && !out_data_q.commit) |-> (out_data_q.hours_bcd == 6'd0 &&
                out_data_q.minutes_bcd == 7'd0 && out_data_q.seconds_bcd == 7'd0),
              "BCD set without commit")
  // Any edge seen in reset leaves both valids low at the next edge
  `CTS_ASSERT_ALWAYS(a_reset_clears,
                     !rst_ni |=> (!out_vld_q && !stage.vld),
                     "valid set during reset")

endmodule

@@ sv/cts_input_stage.sv @@
// ----------------------------------------------------------------------------
// Clock time-set controller input stage
// Registers one key poll beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_input_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cts_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output cts_pkg::stage_t   stage_o
);

  logic              vld_q;
  cts_pkg::in_item_t item_q;

  // Hold the beat while the core cannot take it
  assign in_stall_o = vld_q & ~take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.item = item_q;

endmodule

@@ sv/cts_core.sv @@
// ----------------------------------------------------------------------------
// Clock time-set controller core
// Edit state registers and the single-pass tick update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  cts_pkg::in_item_t  item_i,
  input  logic [6:0]         long_press_i,
  output cts_pkg::out_item_t result_o
);

  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [1:0] field_q, field_d;
  logic [6:0] press_q, press_d;
  logic [1:0] held_q, held_d;
  logic [3:0] blink_q, blink_d;

  logic [1:0] phase;
  logic       commit;
  logic [5:0] hours_inc;
  logic [6:0] minutes_inc;
  logic [6:0] seconds_inc;
  logic [6:0] hours_bcd_full;

  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    field_d   = field_q;
    press_d   = press_q;
    held_d    = held_q;
    commit    = 1'b0;

    // Load the current time, selecting seconds
    if (item_i.action) begin
      hours_d   = item_i.load_hours;
      minutes_d = item_i.load_minutes;
      seconds_d = item_i.load_seconds;
      field_d   = cts_pkg::FieldSeconds;
    end

    // Advance the blink cycle
    if (blink_q <= cts_pkg::BlinkShowLast) begin
      phase   = cts_pkg::PhaseShow;
      blink_d = blink_q + 4'd1;
    end else if (blink_q <= cts_pkg::BlinkBlankLast) begin
      phase   = cts_pkg::PhaseBlank;
      blink_d = blink_q + 4'd1;
    end else begin
      phase   = cts_pkg::PhaseIdle;
      blink_d = 4'd0;
    end

    // Wrapped increments: one compare and subtract covers any stored value
    hours_inc = {1'b0, hours_d} + 6'd1;
    if (hours_inc >= cts_pkg::HoursWrap) begin
      hours_inc = hours_inc - cts_pkg::HoursWrap;
    end
    minutes_inc = {1'b0, minutes_d} + 7'd1;
    if (minutes_inc >= cts_pkg::MinSecWrap) begin
      minutes_inc = minutes_inc - cts_pkg::MinSecWrap;
    end
    seconds_inc = {1'b0, seconds_d} + 7'd1;
    if (seconds_inc >= cts_pkg::MinSecWrap) begin
      seconds_inc = seconds_inc - cts_pkg::MinSecWrap;
    end

    if (item_i.key != cts_pkg::KeyReleased) begin
      if (press_q != cts_pkg::PressMax) begin
        press_d = press_q + 7'd1;
      end
      held_d = item_i.key;
      if (press_d >= long_press_i) begin
        press_d = 7'd0;
        commit  = (item_i.key == cts_pkg::KeyInc);
      end
    end else begin
      // Apply a short press on release
      if (press_q != 7'd0 && press_q < long_press_i) begin
        if (held_q == cts_pkg::KeyInc) begin
          case (field_d)
            cts_pkg::FieldHours:   hours_d   = hours_inc[4:0];
            cts_pkg::FieldMinutes: minutes_d = minutes_inc[5:0];
            cts_pkg::FieldSeconds: seconds_d = seconds_inc[5:0];
            default: ;
          endcase
        end else if (held_q == cts_pkg::KeyNext) begin
          case (field_d)
            cts_pkg::FieldHours:   field_d = cts_pkg::FieldMinutes;
            cts_pkg::FieldMinutes: field_d = cts_pkg::FieldSeconds;
            default:               field_d = cts_pkg::FieldHours;
          endcase
        end
      end
      press_d = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      field_q   <= cts_pkg::FieldHours;
      press_q   <= '0;
      held_q    <= cts_pkg::KeyReleased;
      blink_q   <= '0;
    end else if (adv_i) begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      field_q   <= field_d;
      press_q   <= press_d;
      held_q    <= held_d;
      blink_q   <= blink_d;
    end
  end

  assign hours_bcd_full = cts_pkg::to_bcd({1'b0, hours_d});

  assign result_o.hours          = hours_d;
  assign result_o.minutes        = minutes_d;
  assign result_o.seconds        = seconds_d;
  assign result_o.selected_field = field_d;
  assign result_o.blink_phase    = phase;
  assign result_o.commit         = commit;
  assign result_o.hours_bcd      = commit ? hours_bcd_full[5:0] : 6'd0;
  assign result_o.minutes_bcd    = commit ? cts_pkg::to_bcd(minutes_d) : 7'd0;
  assign result_o.seconds_bcd    = commit ? cts_pkg::to_bcd(seconds_d) : 7'd0;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Clock time-set controller testbench
// Drives key poll beats through the time-set controller with random valid gaps
// and result stalls, mirrors the edit state, blink cycle and long-press commit
// in a local model, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Key code with no package name: any key other than increment or next.
  localparam logic [1:0] KeyOther = 2'd3;
  localparam int unsigned IdlePct = 23;
  localparam int unsigned ReportLimit = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               key_valid = 1'b0;
  logic               key_stall;
  cts_pkg::in_item_t  key_beat = '0;
  logic               view_valid;
  logic               view_stall = 1'b0;
  cts_pkg::out_item_t view_beat;
  logic               limit_valid = 1'b0;
  logic               limit_ready;
  logic [6:0]         limit_data = '0;

  // Local copy of the editor state and the long-press threshold.
  logic [4:0] ed_hours;
  logic [5:0] ed_minutes;
  logic [5:0] ed_seconds;
  logic [1:0] sel_field;
  logic [1:0] last_key;
  logic [6:0] press_cnt;
  logic [3:0] blink_cnt;
  logic [6:0] hold_limit;

  cts_pkg::out_item_t expected_views[$];
  int                 mismatches = 0;
  int                 ticks_sent = 0;
  bit                 calm = 1'b0;

  clock_time_set_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (key_valid),
    .in_stall_o  (key_stall),
    .in_data_i   (key_beat),
    .out_valid_o (view_valid),
    .out_stall_i (view_stall),
    .out_data_o  (view_beat),
    .cfg_valid_i (limit_valid),
    .cfg_ready_o (limit_ready),
    .cfg_data_i  (limit_data)
  );

  always #4 clk = ~clk;

  // Safety net: end the run if a handshake never completes.
  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] bcd_of(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Advance the local editor by one poll tick and return the view it shows.
  function automatic cts_pkg::out_item_t edit_tick(input cts_pkg::in_item_t tick);
    cts_pkg::out_item_t view;
    bit                 commit;
    view   = '0;
    commit = 1'b0;
    // Load first: it also moves the cursor to the seconds field.
    if (tick.action) begin
      ed_hours   = tick.load_hours;
      ed_minutes = tick.load_minutes;
      ed_seconds = tick.load_seconds;
      sel_field  = cts_pkg::FieldSeconds;
    end
    // Blink: six show ticks, four blank ticks, one idle tick.
    if (blink_cnt <= 4'd5) begin
      view.blink_phase = cts_pkg::PhaseShow;
      blink_cnt++;
    end else if (blink_cnt <= 4'd9) begin
      view.blink_phase = cts_pkg::PhaseBlank;
      blink_cnt++;
    end else begin
      view.blink_phase = cts_pkg::PhaseIdle;
      blink_cnt = '0;
    end
    if (tick.key != cts_pkg::KeyReleased) begin
      if (press_cnt < 7'd127) press_cnt++;
      last_key = tick.key;
      // Long press: restart the count, commit only for the increment key.
      if (press_cnt >= hold_limit) begin
        press_cnt = '0;
        commit = (last_key == cts_pkg::KeyInc);
      end
    end else begin
      // Release: apply the press only if it was short.
      if (press_cnt != 0 && press_cnt < hold_limit) begin
        if (last_key == cts_pkg::KeyInc) begin
          case (sel_field)
            cts_pkg::FieldHours: begin
              ed_hours = 5'((ed_hours + 1) % 24);
            end
            cts_pkg::FieldMinutes: begin
              ed_minutes = 6'((ed_minutes + 1) % 60);
            end
            cts_pkg::FieldSeconds: begin
              ed_seconds = 6'((ed_seconds + 1) % 60);
            end
            default: begin
            end
          endcase
        end else if (last_key == cts_pkg::KeyNext) begin
          sel_field = 2'((sel_field + 1) % 3);
        end
      end
      press_cnt = '0;
    end
    view.hours          = ed_hours;
    view.minutes        = ed_minutes;
    view.seconds        = ed_seconds;
    view.selected_field = sel_field;
    view.commit         = commit;
    if (commit) begin
      view.hours_bcd   = 6'(bcd_of(ed_hours));
      view.minutes_bcd = 7'(bcd_of(ed_minutes));
      view.seconds_bcd = 7'(bcd_of(ed_seconds));
    end
    return view;
  endfunction

  function automatic string fmt_view(input cts_pkg::out_item_t v);
    return $sformatf("%0d:%0d:%0d sel=%0d phase=%0d commit=%0d bcd=%h:%h:%h",
                     v.hours, v.minutes, v.seconds, v.selected_field,
                     v.blink_phase, v.commit, v.hours_bcd, v.minutes_bcd,
                     v.seconds_bcd);
  endfunction

  function automatic cts_pkg::in_item_t tick_of(input bit action, input logic [1:0] key,
                                                input logic [4:0] h, input logic [5:0] m,
                                                input logic [5:0] s);
    cts_pkg::in_item_t t;
    t.action       = action;
    t.key          = key;
    t.load_hours   = h;
    t.load_minutes = m;
    t.load_seconds = s;
    return t;
  endfunction

  // Random load values: mostly a legal time, sometimes any bit pattern.
  function automatic cts_pkg::in_item_t random_tick(input logic [1:0] key, input bit action);
    if ($urandom_range(4) == 0)
      return tick_of(action, key, 5'($urandom_range(31)), 6'($urandom_range(63)),
                     6'($urandom_range(63)));
    return tick_of(action, key, 5'($urandom_range(23)), 6'($urandom_range(59)),
                   6'($urandom_range(59)));
  endfunction

  // Result stalls: change at the falling edge, idle never in a calm stretch.
  always @(negedge clk) begin
    view_stall <= !calm && ($urandom_range(99) < IdlePct);
  end

  // Check each accepted result beat against the oldest expected view.
  always @(posedge clk) begin : check_views
    cts_pkg::out_item_t want;
    if (rst_n && view_valid === 1'b1 && !view_stall) begin
      if (expected_views.size() == 0) begin
        if (mismatches < ReportLimit)
          $display("unexpected result beat: %s", fmt_view(view_beat));
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        if (view_beat.hours !== want.hours || view_beat.minutes !== want.minutes ||
            view_beat.seconds !== want.seconds ||
            view_beat.selected_field !== want.selected_field ||
            view_beat.blink_phase !== want.blink_phase ||
            view_beat.commit !== want.commit ||
            view_beat.hours_bcd !== want.hours_bcd ||
            view_beat.minutes_bcd !== want.minutes_bcd ||
            view_beat.seconds_bcd !== want.seconds_bcd) begin
          if (mismatches < ReportLimit)
            $display("view mismatch: expected %s, got %s", fmt_view(want),
                     fmt_view(view_beat));
          mismatches++;
        end
      end
    end
  end

  // Send one poll beat. Starts and ends just after a rising edge; hold the
  // payload while stalled and keep valid high straight into the next beat.
  task automatic send_tick(input cts_pkg::in_item_t tick);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IdlePct) begin
      key_valid <= 1'b0;
      @(negedge clk);
    end
    key_valid <= 1'b1;
    key_beat  <= tick;
    do @(posedge clk); while (key_stall);
    expected_views.push_back(edit_tick(tick));
    ticks_sent++;
  endtask

  task automatic hold_key(input logic [1:0] key, input int n);
    repeat (n) send_tick(tick_of(1'b0, key, '0, '0, '0));
  endtask

  task automatic tap(input logic [1:0] key);
    hold_key(key, 1);
    hold_key(cts_pkg::KeyReleased, 1);
  endtask

  // Drop valid and wait until every expected view has come back.
  task automatic settle();
    @(negedge clk);
    key_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the long-press threshold; call only with the block idle.
  task automatic set_hold_limit(input logic [6:0] v);
    @(negedge clk);
    limit_valid <= 1'b1;
    limit_data  <= v;
    do @(posedge clk); while (!limit_ready);
    hold_limit = v;
    @(negedge clk);
    limit_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Short presses at the reset threshold: wrap seconds and hours, wrap the
  // cursor from seconds back to hours.
  task automatic test_short_presses();
    send_tick(tick_of(1'b1, cts_pkg::KeyReleased, 5'd23, 6'd59, 6'd59));
    tap(cts_pkg::KeyInc);
    tap(cts_pkg::KeyNext);
    tap(cts_pkg::KeyInc);
  endtask

  // Hold the increment key, lower the threshold mid-hold, and expect the very
  // next held tick to commit.
  task automatic test_threshold_lowered_in_hold();
    hold_key(cts_pkg::KeyInc, 5);
    settle();
    set_hold_limit(7'd3);
    hold_key(cts_pkg::KeyInc, 1);
    hold_key(cts_pkg::KeyReleased, 1);
  endtask

  // Load an out-of-range time with the key down, commit it as BCD, then bump
  // the oversized seconds through the modulo wrap.
  task automatic test_out_of_range_commit();
    send_tick(tick_of(1'b1, cts_pkg::KeyInc, 5'd31, 6'd63, 6'd63));
    hold_key(cts_pkg::KeyInc, 2);
    hold_key(cts_pkg::KeyReleased, 1);
    tap(cts_pkg::KeyInc);
  endtask

  // Threshold zero: every held tick commits; a long press of another key
  // only restarts the count.
  task automatic test_threshold_zero();
    settle();
    set_hold_limit(7'd0);
    hold_key(cts_pkg::KeyInc, 2);
    hold_key(KeyOther, 1);
    hold_key(cts_pkg::KeyReleased, 1);
  endtask

  // Random editing at one threshold: mostly press/release sequences with
  // random length and content, plus noise ticks, loads and full drains.
  task automatic test_random_editing(input logic [6:0] limit, input int n_ticks,
                                     input bit quiet);
    int         goal;
    int         pick;
    int         len;
    int         lo;
    logic [1:0] k;
    settle();
    set_hold_limit(limit);
    calm = quiet;
    goal = ticks_sent + n_ticks;
    lo   = (limit < 7'd1) ? 1 : int'(limit);
    while (ticks_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        k = (pick < 60) ? cts_pkg::KeyInc : ((pick < 85) ? cts_pkg::KeyNext : KeyOther);
        if (limit < 7'd2)
          len = $urandom_range(3, 1);
        else if ($urandom_range(1) == 0)
          len = $urandom_range(int'(limit) - 1, 1);
        else
          len = $urandom_range(2 * lo + 2, lo);
        repeat (len) send_tick(random_tick(k, $urandom_range(99) < 3));
        repeat ($urandom_range(3, 1))
          send_tick(random_tick(cts_pkg::KeyReleased, $urandom_range(99) < 3));
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1))
          send_tick(random_tick(2'($urandom_range(3)), 1'($urandom_range(1))));
      end else if (pick < 98) begin
        send_tick(random_tick(cts_pkg::KeyReleased, 1'b1));
      end else begin
        settle();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    ed_hours   = '0;
    ed_minutes = '0;
    ed_seconds = '0;
    sel_field  = cts_pkg::FieldHours;
    last_key   = cts_pkg::KeyReleased;
    press_cnt  = '0;
    blink_cnt  = '0;
    hold_limit = 7'd11;

    // Hold reset, then release it away from the rising edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_presses();
    test_threshold_lowered_in_hold();
    test_out_of_range_commit();
    test_threshold_zero();

    test_random_editing(7'd11, 240, 1'b0);
    test_random_editing(7'd2, 240, 1'b0);
    test_random_editing(7'd1, 240, 1'b0);
    test_random_editing(7'd127, 250, 1'b0);
    test_random_editing(7'd5, 240, 1'b1);
    test_random_editing(7'd0, 240, 1'b0);
    test_random_editing(7'd40, 240, 1'b0);
    test_random_editing(7'($urandom_range(127, 2)), 240, 1'b0);

    // Drain, let any stray beats show up, then judge.
    settle();
    repeat (8) @(posedge clk);
    mismatches += expected_views.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/cts_pkg.sv
sv/cts_input_stage.sv
sv/cts_core.sv
sv/clock_time_set_controller.sv
verif/tb_top.sv
